// ===== rtl/torch_height_control_macros.svh =====
// Assertion macros used by the top level of the torch height controller RTL.
`ifndef TORCH_HEIGHT_CONTROL_MACROS_SVH
`define TORCH_HEIGHT_CONTROL_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define THC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("torch height control: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define THC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("torch height control: next-cycle check failed");

`endif

// ===== rtl/thc_pkg.sv =====
// Package with the shared types and constants of the torch height controller.
package thc_pkg;

    // Event codes carried in the input tuser field.
    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_ARC_ON    = 3'd1,
        FUNC_ARC_OFF   = 3'd2,
        FUNC_ENABLE    = 3'd3,
        FUNC_NEW_BLOCK = 3'd4
    } t_func;

    // Controller state codes, reported in the result.
    typedef enum logic [2:0] {
        CS_IDLE   = 3'd0,
        CS_DELAY  = 3'd1,
        CS_LOCK   = 3'd2,
        CS_WINDOW = 3'd3,
        CS_MANUAL = 3'd4
    } t_ctrl;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_THC_MODE       = 3'd0,
        CFG_DELAY_TICKS    = 3'd1,
        CFG_VOLTAGE_WINDOW = 3'd2,
        CFG_VOLTAGE_SCALE  = 3'd3,
        CFG_VAD_PERCENT    = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] MODE_MANUAL = 2'd2;

    // Shared multiplier geometry.
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Rate thresholds, in 1/10000 mm/min.
    localparam int THR_W = 31;
    localparam logic [MUL_B_W-1:0] RATE_SCALE = 16'd10000;
    localparam logic [MUL_B_W-1:0] LOCK_PCT   = 16'd99;

    // Result packing.
    localparam int ARC_W      = 28;
    localparam int M_DATA_W   = 40;
    localparam int OFS_PULSE  = 0;
    localparam int OFS_DIRUP  = 1;
    localparam int OFS_PAUSE  = 2;
    localparam int OFS_ARC_V  = 3;
    localparam int OFS_CTRL   = 31;
    localparam int OFS_FLAGS  = 34;

    // Configuration register set.
    typedef struct packed {
        logic [1:0]  thc_mode;
        logic [15:0] delay_ticks;
        logic [15:0] voltage_window;
        logic [15:0] voltage_scale;
        logic [6:0]  vad_percent;
    } t_cfg;

    // Request to the shared multiplier.
    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

// ===== rtl/torch_height_control.sv =====
// Top level of the torch height controller: config registers, sequencer and multiplier.
//
// Event-driven plasma torch height controller. Each input transaction carries one
// event (tick, arc on, arc off, enable change, new motion block) in s_axis_tuser and
// yields exactly one result transaction with the Z step request, pause request,
// scaled arc voltage, controller state and status flags. The input is ready again
// only when the event it took has been executed, so one event at a time passes
// through the steps in order: accept, three passes through the single shared 24x16
// multiplier (voltage and feed rate scaling on a tick, the lock and anti-dive
// thresholds on a new block) and execution. A finished result sits in the
// output register, so the next event is accepted while it waits; execution of that
// next event waits only if the previous result is still untaken.
// Configuration writes are taken in every cycle and must be made while idle.
module torch_height_control #(
    parameter int SAMPLE_BITS = 12,
    localparam int S_DW = ((45 + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    // Event stream in.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tuser: func
    input  logic [2:0]                     s_axis_tuser,
    // tdata: voltage_sample, arc_ok_in, up_in, down_in, actual_rate,
    //        block feed rate, override_pct, disable_thc, arc_confirmed, zero pad
    input  logic [S_DW-1:0]                s_axis_tdata,
    // Result stream out.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: step_pulse, step_up, pause_request, scaled arc volts, ctrl_state,
    //        status_flags, zero pad
    output logic [thc_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import thc_pkg::*;

    `include "torch_height_control_macros.svh"

    t_cfg                w_cfg;
    t_mul_req            w_mul_req;
    logic [MUL_P_W-1:0]  w_mul_prod;
    logic [2:0]          w_out_ctrl;
    logic                w_out_pulse;
    logic                w_out_may_step;

    // Configuration registers.
    thc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .o_wr_ready (o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Shared multiplier.
    thc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_mul_prod)
    );

    // Sequencer and controller.
    thc_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_s_user   (s_axis_tuser),
        .i_s_data   (s_axis_tdata),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_data   (m_axis_tdata),
        .o_mul_req  (w_mul_req),
        .i_mul_prod (w_mul_prod)
    );

    assign w_out_ctrl     = m_axis_tdata[OFS_CTRL +: 3];
    assign w_out_pulse    = m_axis_tdata[OFS_PULSE];
    assign w_out_may_step = (w_out_ctrl == CS_WINDOW) || (w_out_ctrl == CS_MANUAL);

    // The sequencer is busy right after it takes an event.
    `THC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // An upward direction is only reported with a step.
    `THC_ASSERT_IMPL(a_dir_with_pulse, m_axis_tvalid && m_axis_tdata[OFS_DIRUP], w_out_pulse)
    // Steps come only from window control or manual follow.
    `THC_ASSERT_IMPL(a_pulse_state, m_axis_tvalid && w_out_pulse, w_out_may_step)

endmodule

// ===== rtl/thc_cfg.sv =====
// Configuration register file of the torch height controller.
module thc_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    output logic              o_wr_ready,
    input  logic [2:0]        i_wr_index,
    input  logic [15:0]       i_wr_data,
    output thc_pkg::t_cfg     o_cfg
);
    import thc_pkg::*;

    t_cfg r_cfg;

    // The register file takes a write in every cycle.
    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thc_mode       <= 2'd1;
            r_cfg.delay_ticks    <= 16'd3000;
            r_cfg.voltage_window <= 16'd256;
            r_cfg.voltage_scale  <= 16'd256;
            r_cfg.vad_percent    <= 7'd90;
        end else if (i_wr_valid) begin
            unique case (i_wr_index)
                CFG_THC_MODE:       r_cfg.thc_mode       <= i_wr_data[1:0];
                CFG_DELAY_TICKS:    r_cfg.delay_ticks    <= i_wr_data;
                CFG_VOLTAGE_WINDOW: r_cfg.voltage_window <= i_wr_data;
                CFG_VOLTAGE_SCALE:  r_cfg.voltage_scale  <= i_wr_data;
                CFG_VAD_PERCENT:    r_cfg.vad_percent    <= i_wr_data[6:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/thc_mul.sv =====
// Shared multiplier of the torch height controller, with a registered product.
module thc_mul (
    input  logic                          i_clk,
    input  thc_pkg::t_mul_req             i_req,
    output logic [thc_pkg::MUL_P_W-1:0]   o_prod
);
    import thc_pkg::*;

    logic [MUL_P_W-1:0] r_prod;

    assign o_prod = r_prod;

    // One product per enabled cycle; the result holds otherwise.
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= MUL_P_W'(i_req.a) * MUL_P_W'(i_req.b);
        end
    end

endmodule

// ===== rtl/thc_core.sv =====
// Sequencer and control state of the torch height controller.
module thc_core #(
    parameter int SAMPLE_BITS = 12,
    localparam int S_DW = ((45 + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  thc_pkg::t_cfg                  i_cfg,
    input  logic                           i_s_valid,
    output logic                           o_s_ready,
    input  logic [2:0]                     i_s_user,
    input  logic [S_DW-1:0]                i_s_data,
    output logic                           o_m_valid,
    input  logic                           i_m_ready,
    output logic [thc_pkg::M_DATA_W-1:0]   o_m_data,
    output thc_pkg::t_mul_req              o_mul_req,
    input  logic [thc_pkg::MUL_P_W-1:0]    i_mul_prod
);
    import thc_pkg::*;

    localparam int VW = SAMPLE_BITS + 16;
    localparam int WW = VW + 2;
    localparam int OFS_ARC_OK = SAMPLE_BITS;
    localparam int OFS_UP     = SAMPLE_BITS + 1;
    localparam int OFS_DOWN   = SAMPLE_BITS + 2;
    localparam int OFS_ACT    = SAMPLE_BITS + 3;
    localparam int OFS_PROG   = SAMPLE_BITS + 19;
    localparam int OFS_OVR    = SAMPLE_BITS + 35;
    localparam int OFS_DIS    = SAMPLE_BITS + 43;
    localparam int OFS_CONF   = SAMPLE_BITS + 44;

    // Positions in the status flags.
    localparam int FB_ARC_OK  = 0;
    localparam int FB_ENABLED = 1;
    localparam int FB_ACTIVE  = 2;
    localparam int FB_TORCH   = 3;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_M0,
        SEQ_M1,
        SEQ_M2,
        SEQ_EXEC
    } t_seq;

    t_seq                     r_seq;
    // Latched transaction fields.
    logic [2:0]               r_func;
    logic [SAMPLE_BITS-1:0]   r_sample;
    logic                     r_arc_ok_in, r_up_in, r_down_in, r_disable, r_confirmed;
    logic [15:0]              r_act_rate, r_prog_rate;
    logic [7:0]               r_ovr;
    // Intermediate products.
    logic [VW-1:0]            r_t0;
    logic [THR_W-1:0]         r_t1;
    // Controller state.
    t_ctrl                    r_mode, n_mode;
    logic [15:0]              r_delay_left, n_delay_left;
    logic signed [WW-1:0]     r_win_lo, n_win_lo, r_win_hi, n_win_hi;
    logic [THR_W-1:0]         r_lock_thr, n_lock_thr, r_anti_thr, n_anti_thr;
    logic [VW-1:0]            r_last_v, n_last_v;
    logic [3:0]               r_flags, n_flags;
    // Result register.
    logic                     r_m_valid;
    logic [M_DATA_W-1:0]      r_m_data;

    logic                     w_tick, w_manual, w_commit, w_lock_ok;
    logic                     w_pulse, w_dir_up, w_pause;
    logic signed [WW-1:0]     w_volt, w_win;
    logic [15:0]              w_dec;

    assign o_s_ready = (r_seq == SEQ_IDLE);
    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

    assign w_tick   = (r_func == FUNC_TICK);
    assign w_manual = (i_cfg.thc_mode == MODE_MANUAL);
    assign w_commit = (r_seq == SEQ_EXEC) && (!r_m_valid || i_m_ready);

    // Multiplier schedule: voltage and rate for ticks, rate thresholds otherwise.
    always_comb begin
        o_mul_req.en = 1'b0;
        o_mul_req.a  = '0;
        o_mul_req.b  = '0;
        unique case (r_seq)
            SEQ_M0: begin
                o_mul_req.en = 1'b1;
                if (w_tick) begin
                    o_mul_req.a = MUL_A_W'(r_sample);
                    o_mul_req.b = i_cfg.voltage_scale;
                end else begin
                    o_mul_req.a = MUL_A_W'(r_prog_rate);
                    o_mul_req.b = MUL_B_W'(r_ovr);
                end
            end
            SEQ_M1: begin
                o_mul_req.en = 1'b1;
                if (w_tick) begin
                    o_mul_req.a = MUL_A_W'(r_act_rate);
                    o_mul_req.b = RATE_SCALE;
                end else begin
                    o_mul_req.a = i_mul_prod[MUL_A_W-1:0];
                    o_mul_req.b = LOCK_PCT;
                end
            end
            SEQ_M2: begin
                o_mul_req.en = 1'b1;
                o_mul_req.a  = r_t0[MUL_A_W-1:0];
                o_mul_req.b  = MUL_B_W'(i_cfg.vad_percent);
            end
            default: ;
        endcase
    end

    // During execution of a tick, r_t0 holds the scaled voltage and r_t1 the scaled rate.
    assign w_volt    = WW'(r_t0);
    assign w_win     = WW'(i_cfg.voltage_window);
    assign w_lock_ok = (r_t1 >= r_lock_thr);
    assign w_dec     = (r_delay_left != 16'd0) ? (r_delay_left - 16'd1) : 16'd0;

    // Event handling: next controller state and the result flags.
    always_comb begin
        n_mode       = r_mode;
        n_delay_left = r_delay_left;
        n_win_lo     = r_win_lo;
        n_win_hi     = r_win_hi;
        n_lock_thr   = r_lock_thr;
        n_anti_thr   = r_anti_thr;
        n_last_v     = r_last_v;
        n_flags      = r_flags;
        w_pulse      = 1'b0;
        w_dir_up     = 1'b0;
        w_pause      = 1'b0;
        unique case (r_func)
            FUNC_TICK: begin
                unique case (r_mode)
                    CS_IDLE: n_last_v = r_t0;
                    CS_DELAY: begin
                        n_delay_left = w_dec;
                        if (w_dec == 16'd0) begin
                            n_flags[FB_ENABLED] = 1'b1;
                            if (w_manual) begin
                                n_mode = CS_MANUAL;
                            end else begin
                                n_win_lo = w_volt - w_win;
                                n_win_hi = w_volt + w_win;
                                n_flags[FB_ACTIVE] = w_lock_ok;
                                n_mode = w_lock_ok ? CS_WINDOW : CS_LOCK;
                            end
                        end
                    end
                    CS_LOCK: begin
                        n_flags[FB_ACTIVE] = w_lock_ok;
                        if (w_lock_ok) n_mode = CS_WINDOW;
                    end
                    CS_WINDOW: begin
                        if (r_t1 < r_anti_thr) begin
                            // Anti-dive: feed has slowed, suspend control.
                            n_flags[FB_ACTIVE] = 1'b0;
                            n_mode = CS_LOCK;
                        end else begin
                            n_flags[FB_ACTIVE] = 1'b1;
                            n_flags[FB_ARC_OK] = r_arc_ok_in;
                            if (r_arc_ok_in) begin
                                n_last_v = r_t0;
                                if (w_volt >= r_win_hi) begin
                                    w_pulse  = 1'b1;
                                    w_dir_up = 1'b1;
                                end else if (w_volt <= r_win_lo) begin
                                    w_pulse = 1'b1;
                                end
                            end else begin
                                w_pause = 1'b1;
                            end
                        end
                    end
                    CS_MANUAL: begin
                        n_flags[FB_ARC_OK] = r_arc_ok_in;
                        if (r_arc_ok_in) begin
                            if (r_up_in) begin
                                w_pulse  = 1'b1;
                                w_dir_up = 1'b1;
                            end else if (r_down_in) begin
                                w_pulse = 1'b1;
                            end
                        end else begin
                            w_pause = 1'b1;
                        end
                    end
                    default: n_mode = CS_IDLE;
                endcase
            end
            FUNC_ARC_ON: begin
                n_flags[FB_ARC_OK] = r_confirmed;
                n_flags[FB_TORCH]  = r_confirmed;
                if (r_confirmed) begin
                    n_delay_left = i_cfg.delay_ticks;
                    n_mode       = CS_DELAY;
                end else begin
                    w_pause = 1'b1;
                end
            end
            FUNC_ARC_OFF: begin
                n_flags[FB_TORCH]   = 1'b0;
                n_flags[FB_ARC_OK]  = 1'b0;
                n_flags[FB_ENABLED] = 1'b0;
                n_mode = CS_IDLE;
            end
            FUNC_ENABLE: begin
                n_flags[FB_ENABLED] = !r_disable;
                if (r_disable) begin
                    n_mode = CS_IDLE;
                end else if (r_flags[FB_ARC_OK]) begin
                    n_mode = w_manual ? CS_MANUAL : CS_WINDOW;
                end
            end
            FUNC_NEW_BLOCK: begin
                n_lock_thr = r_t1;
                n_anti_thr = i_mul_prod[THR_W-1:0];
            end
            default: ;
        endcase
    end

    // Sequencer, controller state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SEQ_IDLE;
            r_m_valid    <= 1'b0;
            r_mode       <= CS_IDLE;
            r_delay_left <= '0;
            r_win_lo     <= '0;
            r_win_hi     <= '0;
            r_lock_thr   <= '0;
            r_anti_thr   <= '0;
            r_last_v     <= '0;
            r_flags      <= '0;
        end else begin
            // A new result may replace a taken one in the same cycle.
            if (w_commit) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_ready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_seq)
                SEQ_IDLE: begin
                    if (i_s_valid) begin
                        r_func      <= i_s_user;
                        r_sample    <= i_s_data[SAMPLE_BITS-1:0];
                        r_arc_ok_in <= i_s_data[OFS_ARC_OK];
                        r_up_in     <= i_s_data[OFS_UP];
                        r_down_in   <= i_s_data[OFS_DOWN];
                        r_act_rate  <= i_s_data[OFS_ACT +: 16];
                        r_prog_rate <= i_s_data[OFS_PROG +: 16];
                        r_ovr       <= i_s_data[OFS_OVR +: 8];
                        r_disable   <= i_s_data[OFS_DIS];
                        r_confirmed <= i_s_data[OFS_CONF];
                        r_seq       <= SEQ_M0;
                    end
                end
                SEQ_M0: r_seq <= SEQ_M1;
                SEQ_M1: begin
                    r_t0  <= i_mul_prod[VW-1:0];
                    r_seq <= SEQ_M2;
                end
                SEQ_M2: begin
                    r_t1  <= i_mul_prod[THR_W-1:0];
                    r_seq <= SEQ_EXEC;
                end
                SEQ_EXEC: begin
                    if (w_commit) begin
                        r_mode       <= n_mode;
                        r_delay_left <= n_delay_left;
                        r_win_lo     <= n_win_lo;
                        r_win_hi     <= n_win_hi;
                        r_lock_thr   <= n_lock_thr;
                        r_anti_thr   <= n_anti_thr;
                        r_last_v     <= n_last_v;
                        r_flags      <= n_flags;
                        r_m_data     <= {2'b00, n_flags, n_mode, ARC_W'(n_last_v),
                                         w_pause, w_dir_up, w_pulse};
                        r_seq        <= SEQ_IDLE;
                    end
                end
                default: r_seq <= SEQ_IDLE;
            endcase
        end
    end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the torch height controller event stream.
`timescale 1ns / 100ps

module tb;
    import thc_pkg::*;

    localparam int S_DW = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES = 10;

    // Status flag bit positions.
    localparam int FLAG_ARC_OK  = 0;
    localparam int FLAG_ENABLED = 1;
    localparam int FLAG_ACTIVE  = 2;
    localparam int FLAG_TORCH   = 3;

    // One input event, field by field.
    typedef struct {
        logic [2:0]  func;
        logic [11:0] sample;
        logic        arc_ok;
        logic        up;
        logic        down;
        logic [15:0] rate;
        logic [15:0] prog;
        logic [7:0]  ovr;
        logic        disable_thc;
        logic        confirmed;
    } t_thc_event;

    // One result, field by field.
    typedef struct packed {
        logic        pulse;
        logic        step_up;
        logic        pause;
        logic [27:0] arc_v;
        logic [2:0]  state;
        logic [3:0]  flags;
    } t_thc_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [15:0]       i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [2:0]        s_axis_tuser;
    logic [S_DW-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;

    // Model of the controller: registers and state.
    t_cfg               cfg;
    t_ctrl              ctl_state;
    logic [15:0]        delay_left;
    logic signed [29:0] win_lo;
    logic signed [29:0] win_hi;
    logic [30:0]        lock_thr;
    logic [30:0]        dive_thr;
    logic [27:0]        arc_v;
    logic [3:0]         flags;

    t_thc_result results_due[$];
    int          mismatches = 0;
    int          events_sent = 0;
    int          quiet_cycles = 0;
    int          hold_left = 0;
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;

    torch_height_control uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Register and state values after reset.
    task automatic reset_model();
        cfg.thc_mode = 2'd1;
        cfg.delay_ticks = 16'd3000;
        cfg.voltage_window = 16'd256;
        cfg.voltage_scale = 16'd256;
        cfg.vad_percent = 7'd90;
        ctl_state = CS_IDLE;
        delay_left = '0;
        win_lo = '0;
        win_hi = '0;
        lock_thr = '0;
        dive_thr = '0;
        arc_v = '0;
        flags = '0;
    endtask

    function automatic logic [27:0] scale_sample(input logic [11:0] s);
        return 28'(s) * 28'(cfg.voltage_scale);
    endfunction

    // Velocity lock: active once the rate reaches 99% of the programmed rate times the override.
    function automatic void check_lock(input logic [29:0] rate10k);
        flags[FLAG_ACTIVE] = (rate10k >= lock_thr);
        if (flags[FLAG_ACTIVE]) begin
            ctl_state = CS_WINDOW;
        end
    endfunction

    // Advances the controller model by one event and returns its result.
    function automatic t_thc_result predict_event(input t_thc_event ev);
        t_thc_result        r;
        logic [29:0]        rate10k;
        logic signed [29:0] v;
        logic               manual;
        r = '0;
        rate10k = 30'(ev.rate) * 30'd10000;
        manual = (cfg.thc_mode == MODE_MANUAL);
        case (ev.func)
            FUNC_TICK: begin
                case (ctl_state)
                    CS_IDLE: arc_v = scale_sample(ev.sample);
                    CS_DELAY: begin
                        if (delay_left != 0) delay_left = delay_left - 1'b1;
                        if (delay_left == 0) begin
                            flags[FLAG_ENABLED] = 1'b1;
                            if (manual) begin
                                ctl_state = CS_MANUAL;
                            end else begin
                                // Target is captured without touching the reported voltage.
                                v = $signed({2'b00, scale_sample(ev.sample)});
                                win_lo = v - $signed({14'd0, cfg.voltage_window});
                                win_hi = v + $signed({14'd0, cfg.voltage_window});
                                ctl_state = CS_LOCK;
                                check_lock(rate10k);
                            end
                        end
                    end
                    CS_LOCK: check_lock(rate10k);
                    CS_WINDOW: begin
                        if (rate10k < dive_thr) begin
                            // Anti-dive: fall back to waiting for velocity lock.
                            flags[FLAG_ACTIVE] = 1'b0;
                            ctl_state = CS_LOCK;
                        end else begin
                            flags[FLAG_ACTIVE] = 1'b1;
                            flags[FLAG_ARC_OK] = ev.arc_ok;
                            if (ev.arc_ok) begin
                                arc_v = scale_sample(ev.sample);
                                v = $signed({2'b00, arc_v});
                                if (v >= win_hi) begin
                                    r.pulse = 1'b1;
                                    r.step_up = 1'b1;
                                end else if (v <= win_lo) begin
                                    r.pulse = 1'b1;
                                end
                            end else begin
                                r.pause = 1'b1;
                            end
                        end
                    end
                    CS_MANUAL: begin
                        flags[FLAG_ARC_OK] = ev.arc_ok;
                        if (ev.arc_ok) begin
                            if (ev.up) begin
                                r.pulse = 1'b1;
                                r.step_up = 1'b1;
                            end else if (ev.down) begin
                                r.pulse = 1'b1;
                            end
                        end else begin
                            r.pause = 1'b1;
                        end
                    end
                    default: ctl_state = CS_IDLE;
                endcase
            end
            FUNC_ARC_ON: begin
                flags[FLAG_TORCH] = 1'b1;
                flags[FLAG_ARC_OK] = ev.confirmed;
                if (ev.confirmed) begin
                    delay_left = cfg.delay_ticks;
                    ctl_state = CS_DELAY;
                end else begin
                    flags[FLAG_TORCH] = 1'b0;
                    r.pause = 1'b1;
                end
            end
            FUNC_ARC_OFF: begin
                flags[FLAG_TORCH] = 1'b0;
                flags[FLAG_ARC_OK] = 1'b0;
                flags[FLAG_ENABLED] = 1'b0;
                ctl_state = CS_IDLE;
            end
            FUNC_ENABLE: begin
                flags[FLAG_ENABLED] = !ev.disable_thc;
                if (ev.disable_thc) begin
                    ctl_state = CS_IDLE;
                end else if (flags[FLAG_ARC_OK]) begin
                    ctl_state = manual ? CS_MANUAL : CS_WINDOW;
                end
            end
            FUNC_NEW_BLOCK: begin
                lock_thr = 31'(ev.prog) * 31'(ev.ovr) * 31'd99;
                dive_thr = 31'(ev.prog) * 31'(ev.ovr) * 31'(cfg.vad_percent);
            end
            default: ;
        endcase
        r.arc_v = arc_v;
        r.state = ctl_state;
        r.flags = flags;
        return r;
    endfunction

    function automatic logic [S_DW-1:0] pack_event(input t_thc_event ev);
        return {7'd0, ev.confirmed, ev.disable_thc, ev.ovr, ev.prog, ev.rate,
                ev.down, ev.up, ev.arc_ok, ev.sample};
    endfunction

    // An event of the given kind with every field random.
    function automatic t_thc_event random_event(input logic [2:0] func);
        t_thc_event ev;
        ev.func = func;
        ev.sample = 12'($urandom_range(0, 4095));
        ev.arc_ok = 1'($urandom_range(0, 1));
        ev.up = 1'($urandom_range(0, 1));
        ev.down = 1'($urandom_range(0, 1));
        ev.rate = 16'($urandom_range(0, 65535));
        ev.prog = 16'($urandom_range(0, 65535));
        ev.ovr = 8'($urandom_range(0, 255));
        ev.disable_thc = 1'($urandom_range(0, 1));
        ev.confirmed = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    // Sends one event, with an occasional gap first, and records its expected result.
    task automatic send_event(input t_thc_event ev);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 99) < 28) gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ev.func;
        s_axis_tdata <= pack_event(ev);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        results_due.push_back(predict_event(ev));
        events_sent++;
    endtask

    // Stops the event stream and waits until every result is out and the block is quiet.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_THC_MODE:       cfg.thc_mode = data[1:0];
            CFG_DELAY_TICKS:    cfg.delay_ticks = data;
            CFG_VOLTAGE_WINDOW: cfg.voltage_window = data;
            CFG_VOLTAGE_SCALE:  cfg.voltage_scale = data;
            CFG_VAD_PERCENT:    cfg.vad_percent = data[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic [15:0] delay_ms,
                                  input logic [15:0] win, input logic [15:0] scale,
                                  input logic [6:0] vad);
        wait_idle();
        write_reg(CFG_THC_MODE, {14'd0, mode});
        write_reg(CFG_DELAY_TICKS, delay_ms);
        write_reg(CFG_VOLTAGE_WINDOW, win);
        write_reg(CFG_VOLTAGE_SCALE, scale);
        write_reg(CFG_VAD_PERCENT, {9'd0, vad});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One cut: new block, arc on, a run of ticks around a target voltage and
    // feed rate with some stray events mixed in, then usually arc off.
    task automatic run_cut(input int n_ticks);
        t_thc_event ev;
        int         eff;
        int         base;
        int         spread;
        int         s;
        int         r;
        ev = random_event(FUNC_NEW_BLOCK);
        if ($urandom_range(0, 9) < 8) begin
            ev.prog = 16'($urandom_range(50, 3000));
            ev.ovr = 8'($urandom_range(10, 200));
        end
        send_event(ev);
        eff = int'(ev.prog) * int'(ev.ovr) / 100;
        base = $urandom_range(0, 4095);
        spread = $urandom_range(0, 40);
        ev = random_event(FUNC_ARC_ON);
        ev.confirmed = ($urandom_range(0, 9) != 0);
        send_event(ev);
        for (int k = 0; k < n_ticks; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                ev = random_event(3'($urandom_range(0, 7)));
            end else begin
                ev = random_event(FUNC_TICK);
                s = base + $urandom_range(0, 2 * spread) - spread;
                if (s < 0) s = 0;
                if (s > 4095) s = 4095;
                ev.sample = 12'(s);
                ev.arc_ok = ($urandom_range(0, 19) != 0);
                if ($urandom_range(0, 9) != 0) begin
                    r = eff * $urandom_range(85, 110) / 100;
                    if (r > 65535) r = 65535;
                    ev.rate = 16'(r);
                end
            end
            send_event(ev);
        end
        if ($urandom_range(0, 9) != 0) send_event(random_event(FUNC_ARC_OFF));
    endtask

    task automatic random_phase(input logic [1:0] mode, input logic [15:0] delay_ms,
                                input logic [15:0] win, input logic [15:0] scale,
                                input logic [6:0] vad, input int n_events);
        int target;
        apply_settings(mode, delay_ms, win, scale, vad);
        target = events_sent + n_events;
        while (events_sent < target) run_cut($urandom_range(3, 30));
    endtask

    // Window mode walk-through: voltage extremes, unknown events, failed and
    // good arc start, delay, lock, steps both ways, arc loss, anti-dive,
    // disable and re-enable straight into window control.
    task automatic test_window_directed();
        t_thc_event ev;
        apply_settings(2'd1, 16'd2, 16'd256, 16'hFFFF, 7'd1);
        ev = random_event(FUNC_TICK);
        ev.sample = 12'hFFF;
        send_event(ev);
        ev.sample = 12'h000;
        send_event(ev);
        send_event(random_event(3'd5));
        send_event(random_event(3'd7));
        ev = random_event(FUNC_NEW_BLOCK);
        ev.prog = 16'hFFFF;
        ev.ovr = 8'hFF;
        send_event(ev);
        ev = random_event(FUNC_ARC_ON);
        ev.confirmed = 1'b0;
        send_event(ev);
        ev.confirmed = 1'b1;
        send_event(ev);
        ev = random_event(FUNC_TICK);
        ev.rate = 16'hFFFF;
        ev.sample = 12'd2048;
        send_event(ev);
        send_event(ev);
        ev = random_event(FUNC_NEW_BLOCK);
        ev.prog = 16'd100;
        ev.ovr = 8'd100;
        send_event(ev);
        ev = random_event(FUNC_TICK);
        ev.rate = 16'd100;
        ev.arc_ok = 1'b1;
        send_event(ev);
        ev.sample = 12'hFFF;
        send_event(ev);
        ev.sample = 12'h000;
        send_event(ev);
        ev.arc_ok = 1'b0;
        send_event(ev);
        ev.rate = 16'd0;
        send_event(ev);
        ev = random_event(FUNC_ENABLE);
        ev.disable_thc = 1'b1;
        send_event(ev);
        ev = random_event(FUNC_ARC_ON);
        ev.confirmed = 1'b1;
        send_event(ev);
        ev = random_event(FUNC_ENABLE);
        ev.disable_thc = 1'b0;
        send_event(ev);
        ev = random_event(FUNC_TICK);
        ev.rate = 16'd100;
        ev.arc_ok = 1'b1;
        ev.sample = 12'd2048;
        send_event(ev);
        send_event(random_event(FUNC_ARC_OFF));
    endtask

    // Manual follow: up, down, both, neither and arc loss.
    task automatic test_manual_directed();
        t_thc_event ev;
        apply_settings(2'd2, 16'd0, 16'd0, 16'd1, 7'd100);
        ev = random_event(FUNC_ARC_ON);
        ev.confirmed = 1'b1;
        send_event(ev);
        ev = random_event(FUNC_TICK);
        ev.arc_ok = 1'b1;
        send_event(ev);
        {ev.up, ev.down} = 2'b10;
        send_event(ev);
        {ev.up, ev.down} = 2'b01;
        send_event(ev);
        {ev.up, ev.down} = 2'b11;
        send_event(ev);
        {ev.up, ev.down} = 2'b00;
        send_event(ev);
        ev.arc_ok = 1'b0;
        send_event(ev);
    endtask

    // Random cuts over a sweep of register settings, extremes included.
    task automatic test_settings_sweep();
        random_phase(2'd1, 16'd3, 16'd256, 16'd256, 7'd90, 75);
        random_phase(2'd2, 16'd0, 16'd0, 16'd1, 7'd1, 65);
        random_phase(2'd1, 16'd0, 16'd0, 16'hFFFF, 7'd100, 75);
        random_phase(2'd3, 16'd2, 16'hFFFF, 16'd4096, 7'd127, 65);
        random_phase(2'd0, 16'hFFFF, 16'd1000, 16'd300, 7'd50, 30);
        random_phase(2'd1, 16'd1, 16'd2000, 16'd1024, 7'd0, 75);
        random_phase(2'd2, 16'd4, 16'd500, 16'd256, 7'd90, 65);
    endtask

    // The result side holds off for a long stretch while events keep coming.
    task automatic test_backpressure();
        apply_settings(2'd2, 16'd1, 16'd300, 16'd512, 7'd80);
        sender_gaps = 1'b0;
        hold_left = HOLD_CYCLES;
        run_cut(38);
        sender_gaps = 1'b1;
    endtask

    // Both sides at full rate, no idling at all.
    task automatic test_full_rate();
        int target;
        apply_settings(2'd1, 16'd0, 16'd128, 16'd256, 7'd95);
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        target = events_sent + 60;
        while (events_sent < target) run_cut($urandom_range(5, 20));
        wait_idle();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // Result side: random stalls, or a counted hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (receiver_stalls) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 28);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [27:0] want,
                               input logic [27:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compares each result transaction with the oldest expected result.
    always @(posedge i_clk) begin
        t_thc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = results_due.pop_front();
                check_field("step_pulse", want.pulse, m_axis_tdata[OFS_PULSE]);
                check_field("step_up", want.step_up, m_axis_tdata[OFS_DIRUP]);
                check_field("pause_request", want.pause, m_axis_tdata[OFS_PAUSE]);
                check_field("scaled_volts", want.arc_v, m_axis_tdata[OFS_ARC_V +: ARC_W]);
                check_field("ctrl_state", want.state, m_axis_tdata[OFS_CTRL +: 3]);
                check_field("status_flags", want.flags, m_axis_tdata[OFS_FLAGS +: 4]);
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_THC_MODE;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = FUNC_TICK;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        reset_model();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_window_directed();
        test_manual_directed();
        test_settings_sweep();
        test_backpressure();
        test_full_rate();
        wait_idle();

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
